>>> hw/rtl/rcle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcle_pkg: shared types and constants for the clip rectangle list enumerator
// Holds the word formats of the channels, the table entry layout, the
// configuration register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package rcle_pkg;

  localparam int MAX_CLIP_RECTS = 32;
  localparam int IDX_W          = $clog2(MAX_CLIP_RECTS);
  localparam int CNT_W          = $clog2(MAX_CLIP_RECTS + 1);
  localparam int COORD_W        = 18;

  localparam logic [CNT_W-1:0] MAX_RECTS_C = CNT_W'(MAX_CLIP_RECTS);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef enum logic [1:0] {
    CFG_RECT_COUNT = 2'd0,
    CFG_OFFSET_X   = 2'd1,
    CFG_OFFSET_Y   = 2'd2
  } cfg_index_t;

  typedef enum logic {
    MODE_WRITE = 1'b0,
    MODE_CLIP  = 1'b1
  } req_mode_t;

  typedef struct packed {
    logic              mode;
    logic [4:0]        entry_index;
    logic signed [15:0] x_low;
    logic signed [15:0] y_low;
    logic signed [15:0] x_high_or_width;
    logic signed [15:0] y_high_or_height;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] piece_x_low;
    logic signed [15:0] piece_y_low;
    logic signed [15:0] piece_x_high;
    logic signed [15:0] piece_y_high;
    logic               last_piece;
  } out_word_t;

  typedef struct packed {
    logic signed [15:0] xmin;
    logic signed [15:0] ymin;
    logic signed [15:0] xmax;
    logic signed [15:0] ymax;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [CNT_W-1:0]   rect_count;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
  } cfg_regs_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CUR,
    S_FWD,
    S_BACK,
    S_FIND,
    S_ENTRY,
    S_ABSORB,
    S_NEXT,
    S_FLUSH
  } eng_state_t;

  function automatic coord_t ext16(input logic signed [15:0] v);
    return {{(COORD_W-16){v[15]}}, v};
  endfunction

  function automatic coord_t cmax(input coord_t a, input coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic coord_t cmin(input coord_t a, input coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic out_word_t mk_piece(input coord_t a, input coord_t b,
                                         input coord_t c, input coord_t d);
    out_word_t p;
    p.piece_x_low  = a[15:0];
    p.piece_y_low  = b[15:0];
    p.piece_x_high = c[15:0];
    p.piece_y_high = d[15:0];
    p.last_piece   = 1'b0;
    return p;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rcle_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcle_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rcle_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

>>> hw/rtl/rcle_cfg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcle_cfg: configuration registers
// Holds the entry count and the request translation, written over the
// configuration channel.
// ----------------------------------------------------------------------------
module rcle_cfg
  import rcle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  output      logic       cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data,
  output      cfg_regs_t  regs
);

  cfg_regs_t regs_r, regs_nxt;

  assign cfg_ready = 1'b1;
  assign regs      = regs_r;

  always_comb begin
    regs_nxt = regs_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RECT_COUNT: regs_nxt.rect_count = cfg_data[CNT_W-1:0];
        CFG_OFFSET_X:   regs_nxt.offset_x   = cfg_data;
        CFG_OFFSET_Y:   regs_nxt.offset_y   = cfg_data;
        default:        regs_nxt = regs_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/rcle_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcle_engine: band search and clipping sequencer
// Walks the clip table one entry per read, finds the first band under the
// request, clips each entry against it and merges abutting full-width
// entries. One piece is held back so the final one can be flagged.
// ----------------------------------------------------------------------------
module rcle_engine
  import rcle_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output      logic             busy,
  input  wire in_word_t         in_data,
  input  wire cfg_regs_t        cfg,
  output      logic             out_valid,
  output      out_word_t        out_data,
  output      logic             ram_we,
  output      logic [IDX_W-1:0] ram_waddr,
  output      entry_t           ram_wdata,
  output      logic [IDX_W-1:0] ram_raddr,
  input  wire entry_t           ram_rdata
);

  eng_state_t       state_r, state_nxt;
  coord_t           x_r, x_nxt, y_r, y_nxt, xe_r, xe_nxt, ye_r, ye_nxt;
  coord_t           w_r, w_nxt;
  coord_t           cur_ymax_r, cur_ymax_nxt;
  coord_t           yc_r, yc_nxt, yec_r, yec_nxt, band_r, band_nxt;
  coord_t           xc_r, xc_nxt, xec_r, xec_nxt;
  logic [CNT_W-1:0] n_r, n_nxt, i_r, i_nxt;
  logic [IDX_W-1:0] cursor_r, cursor_nxt;
  out_word_t        pend_r, pend_nxt;
  logic             pend_v_r, pend_v_nxt;
  logic             out_v_r, out_v_nxt;
  out_word_t        out_r, out_nxt;

  coord_t           ex0, ey0, ex1, ey1;
  coord_t           req_x, req_y, req_xe, req_ye;
  coord_t           clip_xc, clip_xec;
  logic [CNT_W-1:0] n_eff, cur_sel, i_inc;
  logic             req_ok;

  assign ex0 = ext16(ram_rdata.xmin);
  assign ey0 = ext16(ram_rdata.ymin);
  assign ex1 = ext16(ram_rdata.xmax);
  assign ey1 = ext16(ram_rdata.ymax);

  assign req_x  = ext16(in_data.x_low) + ext16(cfg.offset_x);
  assign req_y  = ext16(in_data.y_low) + ext16(cfg.offset_y);
  assign req_xe = req_x + ext16(in_data.x_high_or_width);
  assign req_ye = req_y + ext16(in_data.y_high_or_height);
  assign req_ok = !in_data.x_high_or_width[15] && (|in_data.x_high_or_width) &&
                  !in_data.y_high_or_height[15] && (|in_data.y_high_or_height);

  assign n_eff   = (cfg.rect_count > MAX_RECTS_C) ? MAX_RECTS_C : cfg.rect_count;
  assign cur_sel = ({1'b0, cursor_r} < n_eff) ? {1'b0, cursor_r}
                                              : n_eff - CNT_W'(1);
  assign i_inc   = i_r + CNT_W'(1);

  assign clip_xc  = cmax(ex0, x_r);
  assign clip_xec = cmin(ex1, xe_r);

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign ram_we    = start && (state_r == S_IDLE) && (in_data.mode == MODE_WRITE);
  assign ram_waddr = in_data.entry_index[IDX_W-1:0];
  assign ram_wdata = {in_data.x_low, in_data.y_low,
                      in_data.x_high_or_width, in_data.y_high_or_height};

  always_comb begin
    logic      emit_req;
    out_word_t emit_piece;

    state_nxt    = state_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    xe_nxt       = xe_r;
    ye_nxt       = ye_r;
    w_nxt        = w_r;
    cur_ymax_nxt = cur_ymax_r;
    yc_nxt       = yc_r;
    yec_nxt      = yec_r;
    band_nxt     = band_r;
    xc_nxt       = xc_r;
    xec_nxt      = xec_r;
    n_nxt        = n_r;
    i_nxt        = i_r;
    cursor_nxt   = cursor_r;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    out_v_nxt    = 1'b0;
    out_nxt      = out_r;
    ram_raddr    = '0;
    emit_req     = 1'b0;
    emit_piece   = pend_r;

    unique case (state_r)
      S_IDLE: begin
        if (start && in_data.mode == MODE_CLIP && req_ok && n_eff != '0) begin
          x_nxt     = req_x;
          y_nxt     = req_y;
          xe_nxt    = req_xe;
          ye_nxt    = req_ye;
          w_nxt     = ext16(in_data.x_high_or_width);
          n_nxt     = n_eff;
          i_nxt     = cur_sel;
          ram_raddr = cur_sel[IDX_W-1:0];
          state_nxt = S_CUR;
        end
      end

      S_CUR: begin
        if (y_r >= ey0 && ye_r <= ey1 && x_r >= ex0 && xe_r <= ex1) begin
          emit_req   = 1'b1;
          emit_piece = mk_piece(x_r, y_r, xe_r, ye_r);
          state_nxt  = S_FLUSH;
        end else begin
          cur_ymax_nxt = ey1;
          if (y_r >= ey1) begin
            i_nxt = i_inc;
            if (i_inc < n_r) begin
              ram_raddr = i_inc[IDX_W-1:0];
              state_nxt = S_FWD;
            end else begin
              state_nxt = S_FIND;
            end
          end else if (i_r != '0) begin
            ram_raddr = IDX_W'(i_r - CNT_W'(1));
            state_nxt = S_BACK;
          end else begin
            ram_raddr = i_r[IDX_W-1:0];
            state_nxt = S_FIND;
          end
        end
      end

      S_FWD: begin
        if (y_r >= ey1) begin
          i_nxt = i_inc;
          if (i_inc < n_r) begin
            ram_raddr = i_inc[IDX_W-1:0];
          end else begin
            state_nxt = S_FIND;
          end
        end else begin
          ram_raddr = i_r[IDX_W-1:0];
          state_nxt = S_FIND;
        end
      end

      S_BACK: begin
        if (y_r < ey1) begin
          i_nxt = i_r - CNT_W'(1);
          if (i_r > CNT_W'(1)) begin
            ram_raddr = IDX_W'(i_r - CNT_W'(2));
          end else begin
            ram_raddr = '0;
            state_nxt = S_FIND;
          end
        end else begin
          ram_raddr = i_r[IDX_W-1:0];
          state_nxt = S_FIND;
        end
      end

      S_FIND: begin
        if (i_r >= n_r || ey0 >= ye_r) begin
          if (n_r > CNT_W'(1)) begin
            if (i_r < n_r) begin
              cursor_nxt = i_r[IDX_W-1:0];
            end else if (y_r >= cur_ymax_r) begin
              cursor_nxt = IDX_W'(n_r - CNT_W'(1));
            end else begin
              cursor_nxt = '0;
            end
          end
          state_nxt = S_IDLE;
        end else begin
          cursor_nxt = i_r[IDX_W-1:0];
          yc_nxt     = cmax(ey0, y_r);
          band_nxt   = ey1;
          yec_nxt    = cmin(ey1, ye_r);
          ram_raddr  = i_r[IDX_W-1:0];
          state_nxt  = S_ENTRY;
        end
      end

      S_ENTRY: begin
        i_nxt = i_inc;
        if (clip_xec > clip_xc && coord_t'(clip_xec - clip_xc) == w_r) begin
          xc_nxt  = clip_xc;
          xec_nxt = clip_xec;
          if (i_inc < n_r) begin
            ram_raddr = i_inc[IDX_W-1:0];
            state_nxt = S_ABSORB;
          end else begin
            emit_req   = 1'b1;
            emit_piece = mk_piece(clip_xc, yc_r, clip_xec, yec_r);
            state_nxt  = S_FLUSH;
          end
        end else begin
          if (clip_xec > clip_xc) begin
            emit_req   = 1'b1;
            emit_piece = mk_piece(clip_xc, yc_r, clip_xec, yec_r);
          end
          if (i_inc < n_r) begin
            ram_raddr = i_inc[IDX_W-1:0];
            state_nxt = S_NEXT;
          end else begin
            state_nxt = S_FLUSH;
          end
        end
      end

      S_ABSORB: begin
        if (ey0 == yec_r && ey1 <= ye_r && ex0 <= x_r && ex1 >= xe_r) begin
          yec_nxt = ey1;
          i_nxt   = i_inc;
          if (i_inc < n_r) begin
            ram_raddr = i_inc[IDX_W-1:0];
          end else begin
            emit_req   = 1'b1;
            emit_piece = mk_piece(xc_r, yc_r, xec_r, ey1);
            state_nxt  = S_FLUSH;
          end
        end else begin
          emit_req   = 1'b1;
          emit_piece = mk_piece(xc_r, yc_r, xec_r, yec_r);
          ram_raddr  = i_r[IDX_W-1:0];
          state_nxt  = S_NEXT;
        end
      end

      S_NEXT: begin
        ram_raddr = i_r[IDX_W-1:0];
        if (ey1 == band_r) begin
          state_nxt = S_ENTRY;
        end else if (ey0 >= ye_r) begin
          state_nxt = S_FLUSH;
        end else begin
          yc_nxt    = ey0;
          band_nxt  = ey1;
          yec_nxt   = cmin(ey1, ye_r);
          state_nxt = S_ENTRY;
        end
      end

      S_FLUSH: begin
        if (pend_v_r) begin
          out_v_nxt          = 1'b1;
          out_nxt            = pend_r;
          out_nxt.last_piece = 1'b1;
        end
        pend_v_nxt = 1'b0;
        state_nxt  = S_IDLE;
      end

      default: state_nxt = S_IDLE;
    endcase

    if (emit_req) begin
      if (pend_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = pend_r;
      end
      pend_nxt   = emit_piece;
      pend_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cursor_r <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cursor_r <= cursor_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    xe_r       <= xe_nxt;
    ye_r       <= ye_nxt;
    w_r        <= w_nxt;
    cur_ymax_r <= cur_ymax_nxt;
    yc_r       <= yc_nxt;
    yec_r      <= yec_nxt;
    band_r     <= band_nxt;
    xc_r       <= xc_nxt;
    xec_r      <= xec_nxt;
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
  end

endmodule
`default_nettype wire

>>> hw/rtl/rect_clip_list_enumerate.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rect_clip_list_enumerate: banded clip rectangle list enumerator
// Clips request rectangles against a y-banded table of clip rectangles and
// emits the visible pieces in table order.
//
// A command word is taken when start is high and busy is low. Mode 0 writes
// one table entry in that cycle and busy stays low. Mode 1 clips a request:
// busy rises and a sequencer walks the table through one RAM read port with
// registered data, issuing one read per cycle. Busy stays high through the
// band search, the clipping of entries against the bands under the request
// and the merging of abutting full-width entries. A request that lies inside
// the cursor entry comes out whole as one piece, with no search.
// An empty request or empty table finishes at once.
// Each piece appears on out_data for one cycle with out_valid high; the last
// piece of a request has last_piece set and comes in the same cycle that busy
// falls. The receiver cannot hold results off. Configuration words are taken
// on the cfg channel at any time but are meant to be written only while busy
// is low. Reset clears the count, the offsets and the search cursor; table
// contents are undefined until written.
// ----------------------------------------------------------------------------
module rect_clip_list_enumerate
  import rcle_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output      logic       busy,
  input  wire in_word_t   in_data,
  output      logic       out_valid,
  output      out_word_t  out_data,
  input  wire logic       cfg_valid,
  output      logic       cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data
);

  cfg_regs_t        cfg;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;
  entry_t           ram_wdata, ram_rdata;

  rcle_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (cfg)
  );

  rcle_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_CLIP_RECTS)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  rcle_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_data  (out_data),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule
`default_nettype wire

>>> sim/clip_list_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clip_list_checker: scoreboard for the clip rectangle list enumerator
// Watches the command, result and configuration channels, keeps its own copy
// of the clip table, the search cursor and the registers, predicts the pieces
// of every accepted clip request and compares each result word against the
// oldest predicted piece.
// ----------------------------------------------------------------------------
module clip_list_checker
  import rcle_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic        busy,
  input  wire in_word_t    in_data,
  input  wire logic        out_valid,
  input  wire out_word_t   out_data,
  input  wire logic        cfg_valid,
  input  wire logic        cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        drain_done,
  output int               pending,
  output int               fail_count,
  output int               clip_count,
  output int               write_count,
  output int               cfg_count,
  output int               piece_count
);

  localparam int PIECE_CAP = 32;

  int ent_xmin [MAX_CLIP_RECTS];
  int ent_ymin [MAX_CLIP_RECTS];
  int ent_xmax [MAX_CLIP_RECTS];
  int ent_ymax [MAX_CLIP_RECTS];
  int cursor;
  int rect_count_r;
  int shift_x;
  int shift_y;
  out_word_t expected_pieces[$];
  bit drained;

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 40) begin
      $display("ERROR at %0t: %s", $time, msg);
    end
  endtask

  function automatic out_word_t piece_word(input int a, input int b, input int c, input int d);
    out_word_t p;
    p.piece_x_low  = a[15:0];
    p.piece_y_low  = b[15:0];
    p.piece_x_high = c[15:0];
    p.piece_y_high = d[15:0];
    p.last_piece   = 1'b0;
    return p;
  endfunction

  function automatic void predict_pieces(input in_word_t w);
    out_word_t found [PIECE_CAP];
    int x, y, xe, ye, wd, ht, n, cur, i, yc, yec, band_ymax, xc, xec, np, k;
    bit done, same_band;
    np = 0;
    wd = $signed(w.x_high_or_width);
    ht = $signed(w.y_high_or_height);
    if (wd <= 0 || ht <= 0) return;
    x = $signed(w.x_low) + shift_x;
    y = $signed(w.y_low) + shift_y;
    xe = x + wd;
    ye = y + ht;
    n = (rect_count_r > MAX_CLIP_RECTS) ? MAX_CLIP_RECTS : rect_count_r;
    if (n == 0) return;
    cur = (cursor < n) ? cursor : n - 1;
    if (y >= ent_ymin[cur] && ye <= ent_ymax[cur] && x >= ent_xmin[cur] &&
        xe <= ent_xmax[cur]) begin
      found[0] = piece_word(x, y, xe, ye);
      np = 1;
    end else begin
      i = cur;
      if (y >= ent_ymax[cur]) begin
        i = cur + 1;
        while (i < n && y >= ent_ymax[i]) i++;
      end else begin
        while (i > 0 && y < ent_ymax[i - 1]) i--;
      end
      if (i >= n || ent_ymin[i] >= ye) begin
        if (n > 1) begin
          cursor = (i < n) ? i : ((y >= ent_ymax[cur]) ? n - 1 : 0);
        end
      end else begin
        cursor = i;
        yc = (ent_ymin[i] < y) ? y : ent_ymin[i];
        done = 1'b0;
        while (!done) begin
          band_ymax = ent_ymax[i];
          yec = (band_ymax < ye) ? band_ymax : ye;
          same_band = 1'b1;
          while (same_band) begin
            xc = (ent_xmin[i] < x) ? x : ent_xmin[i];
            xec = (ent_xmax[i] > xe) ? xe : ent_xmax[i];
            i++;
            if (xec > xc) begin
              if (xec - xc == wd) begin
                while (i < n && ent_ymin[i] == yec && ent_ymax[i] <= ye &&
                       ent_xmin[i] <= x && ent_xmax[i] >= xe) begin
                  yec = ent_ymax[i];
                  i++;
                end
              end
              if (np < PIECE_CAP) begin
                found[np] = piece_word(xc, yc, xec, yec);
                np++;
              end
            end
            if (i >= n) begin
              done = 1'b1;
              same_band = 1'b0;
            end else begin
              same_band = (ent_ymax[i] == band_ymax);
            end
          end
          if (!done) begin
            yc = ent_ymin[i];
            if (yc >= ye) done = 1'b1;
          end
        end
      end
    end
    for (k = 0; k < np; k++) begin
      if (k == np - 1) found[k].last_piece = 1'b1;
      expected_pieces.push_back(found[k]);
    end
  endfunction

  task automatic check_piece(input out_word_t got);
    out_word_t want;
    if (expected_pieces.size() == 0) begin
      report_mismatch($sformatf("piece (%0d,%0d)-(%0d,%0d) with no piece predicted",
                                got.piece_x_low, got.piece_y_low,
                                got.piece_x_high, got.piece_y_high));
      return;
    end
    want = expected_pieces.pop_front();
    piece_count++;
    if (got.piece_x_low !== want.piece_x_low)
      report_mismatch($sformatf("piece_x_low %0d, expected %0d",
                                got.piece_x_low, want.piece_x_low));
    if (got.piece_y_low !== want.piece_y_low)
      report_mismatch($sformatf("piece_y_low %0d, expected %0d",
                                got.piece_y_low, want.piece_y_low));
    if (got.piece_x_high !== want.piece_x_high)
      report_mismatch($sformatf("piece_x_high %0d, expected %0d",
                                got.piece_x_high, want.piece_x_high));
    if (got.piece_y_high !== want.piece_y_high)
      report_mismatch($sformatf("piece_y_high %0d, expected %0d",
                                got.piece_y_high, want.piece_y_high));
    if (got.last_piece !== want.last_piece)
      report_mismatch($sformatf("last_piece %0b, expected %0b",
                                got.last_piece, want.last_piece));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      rect_count_r = 0;
      shift_x = 0;
      shift_y = 0;
      cursor = 0;
      expected_pieces.delete();
    end else begin
      if (out_valid) check_piece(out_data);
      if (cfg_valid && cfg_ready) begin
        cfg_count++;
        case (cfg_index)
          CFG_RECT_COUNT: rect_count_r = cfg_data[5:0];
          CFG_OFFSET_X: shift_x = $signed(cfg_data);
          CFG_OFFSET_Y: shift_y = $signed(cfg_data);
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (in_data.mode == MODE_WRITE) begin
          write_count++;
          ent_xmin[in_data.entry_index] = $signed(in_data.x_low);
          ent_ymin[in_data.entry_index] = $signed(in_data.y_low);
          ent_xmax[in_data.entry_index] = $signed(in_data.x_high_or_width);
          ent_ymax[in_data.entry_index] = $signed(in_data.y_high_or_height);
        end else begin
          clip_count++;
          predict_pieces(in_data);
        end
      end
      if (drain_done && !drained) begin
        drained = 1'b1;
        while (expected_pieces.size() != 0) begin
          report_mismatch($sformatf("predicted piece (%0d,%0d)-(%0d,%0d) never came",
                                    expected_pieces[0].piece_x_low,
                                    expected_pieces[0].piece_y_low,
                                    expected_pieces[0].piece_x_high,
                                    expected_pieces[0].piece_y_high));
          void'(expected_pieces.pop_front());
        end
      end
    end
    pending = expected_pieces.size();
  end

endmodule

>>> sim/rect_clip_list_enumerate_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rect_clip_list_enumerate_test: testbench for the clip list enumerator
// Loads banded clip tables, sends directed and random clip requests under a
// series of count and translation settings, with random gaps on the command
// side, and leaves all checking to the scoreboard instantiated beside the
// block.
// ----------------------------------------------------------------------------
module rect_clip_list_enumerate_test
  import rcle_pkg::*;
();

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  in_word_t    in_data;
  logic        out_valid;
  out_word_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        drain_done;

  int pending, fail_count, clip_count, write_count, cfg_count, piece_count;

  int lay_x0 [MAX_CLIP_RECTS];
  int lay_y0 [MAX_CLIP_RECTS];
  int lay_x1 [MAX_CLIP_RECTS];
  int lay_y1 [MAX_CLIP_RECTS];
  int lay_n;
  int area_x0, area_x1, area_y0, area_y1;
  int cur_offx, cur_offy;
  bit gaps_on;

  rect_clip_list_enumerate uut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  clip_list_checker clip_check (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .drain_done(drain_done),
    .pending(pending),
    .fail_count(fail_count),
    .clip_count(clip_count),
    .write_count(write_count),
    .cfg_count(cfg_count),
    .piece_count(piece_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [15:0] to_field(input int v);
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  task automatic send_word(input in_word_t w);
    start = 1'b1;
    in_data = w;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic send_entry(input int idx, input int x0, input int y0,
                            input int x1, input int y1);
    in_word_t w;
    w.mode = MODE_WRITE;
    w.entry_index = idx[4:0];
    w.x_low = x0[15:0];
    w.y_low = y0[15:0];
    w.x_high_or_width = x1[15:0];
    w.y_high_or_height = y1[15:0];
    send_word(w);
  endtask

  task automatic send_clip(input int x, input int y, input int wd, input int ht);
    in_word_t w;
    w.mode = MODE_CLIP;
    w.entry_index = 5'($urandom);
    w.x_low = x[15:0];
    w.y_low = y[15:0];
    w.x_high_or_width = wd[15:0];
    w.y_high_or_height = ht[15:0];
    send_word(w);
  endtask

  task automatic write_cfg(input cfg_index_t idx, input int v);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = v[15:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic apply_setting(input int cnt, input int ox, input int oy);
    write_cfg(CFG_RECT_COUNT, cnt);
    write_cfg(CFG_OFFSET_X, ox);
    write_cfg(CFG_OFFSET_Y, oy);
    cur_offx = ox;
    cur_offy = oy;
  endtask

  task automatic wait_drained();
    start = 1'b0;
    while (pending != 0) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (150) @(negedge clk);
  endtask

  task automatic load_table(input int n, input int bx, input int by);
    int k, j, per, x, y0, y1;
    k = 0;
    y1 = by;
    area_x0 = bx;
    area_x1 = bx + 20;
    area_y0 = by;
    while (k < n) begin
      y0 = ($urandom_range(0, 2) == 0) ? y1 : y1 + $urandom_range(1, 8);
      y1 = y0 + $urandom_range(1, 12);
      if ($urandom_range(0, 2) == 0) begin
        lay_x0[k] = -32768;
        lay_x1[k] = 32767;
        lay_y0[k] = y0;
        lay_y1[k] = y1;
        k++;
      end else begin
        per = $urandom_range(1, 4);
        x = bx;
        for (j = 0; j < per && k < n; j++) begin
          lay_x0[k] = x + $urandom_range(0, 6);
          lay_x1[k] = lay_x0[k] + $urandom_range(1, 15);
          lay_y0[k] = y0;
          lay_y1[k] = y1;
          x = lay_x1[k];
          if (x > area_x1) area_x1 = x;
          k++;
        end
      end
    end
    area_y1 = y1;
    lay_n = n;
    for (k = 0; k < n; k++) begin
      send_entry(k, lay_x0[k], lay_y0[k], lay_x1[k], lay_y1[k]);
    end
  endtask

  function automatic in_word_t make_clip();
    in_word_t w;
    int r, k, span, tx, ty, wd, ht;
    r = $urandom_range(0, 19);
    tx = area_x0 - 10 + $urandom_range(0, area_x1 - area_x0 + 20);
    ty = area_y0 - 10 + $urandom_range(0, area_y1 - area_y0 + 20);
    wd = $urandom_range(1, 40);
    ht = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 40);
    if (r < 6 && lay_n > 0) begin
      k = $urandom_range(0, lay_n - 1);
      span = lay_x1[k] - lay_x0[k];
      if (span > 31) span = 31;
      tx = lay_x0[k] + $urandom_range(0, span - 1);
      wd = $urandom_range(1, lay_x0[k] + span - tx);
      span = lay_y1[k] - lay_y0[k];
      if (span > 31) span = 31;
      ty = lay_y0[k] + $urandom_range(0, span - 1);
      ht = $urandom_range(1, lay_y0[k] + span - ty);
    end else if (r == 6) begin
      wd = -int'($urandom_range(0, 32768));
    end else if (r == 7) begin
      ht = -int'($urandom_range(0, 32768));
    end else if (r == 8 || r == 9) begin
      tx = area_x0 - $urandom_range(0, 200);
      wd = $urandom_range(300, 32767);
    end
    w.mode = MODE_CLIP;
    w.entry_index = 5'($urandom);
    if (r >= 18) begin
      w.x_low = 16'($urandom);
      w.y_low = 16'($urandom);
      w.x_high_or_width = 16'($urandom);
      w.y_high_or_height = 16'($urandom);
    end else begin
      w.x_low = to_field(tx - cur_offx);
      w.y_low = to_field(ty - cur_offy);
      w.x_high_or_width = wd[15:0];
      w.y_high_or_height = ht[15:0];
    end
    return w;
  endfunction

  initial begin
    int ph, k, n;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RECT_COUNT;
    cfg_data = '0;
    drain_done = 1'b0;
    gaps_on = 1'b1;
    lay_n = 0;
    area_x0 = -10;
    area_x1 = 60;
    area_y0 = -10;
    area_y1 = 60;
    cur_offx = 0;
    cur_offy = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_clip(0, 0, 10, 10);
    send_entry(0, 0, 0, 10, 10);
    send_entry(1, 20, 0, 30, 10);
    send_entry(2, -32768, 10, 32767, 20);
    send_entry(3, -32768, 20, 32767, 30);
    send_entry(4, 5, 40, 15, 32767);
    send_entry(31, -32768, -32768, 32767, 32767);
    settle();
    apply_setting(5, 0, 0);
    send_clip(2, 2, 3, 3);
    send_clip(-5, -5, 50, 60);
    send_clip(0, 0, 0, 5);
    send_clip(0, 0, -32768, 5);
    send_clip(0, 0, 5, 0);
    send_clip(0, 0, 5, -1);
    send_clip(-32768, -32768, 32767, 32767);
    send_clip(32767, 32767, 32767, 32767);
    send_clip(-10, -100, 50, 10);
    send_clip(8, 35, 4, 3);
    send_clip(0, 32767, 1, 1);
    send_clip(-32768, 5, 32767, 30);
    settle();
    apply_setting(5, 32767, -32768);
    send_clip(-32768, 32767, 20, 20);
    send_clip(32767, -32768, 1, 1);

    for (ph = 0; ph < 7; ph++) begin
      settle();
      case (ph)
        0: begin
          n = 8;
          apply_setting(8, 0, 0);
          load_table(n, 0, 0);
        end
        1: begin
          n = 32;
          apply_setting(32, 3, -4);
          load_table(n, -50, 100);
        end
        2: begin
          n = 32;
          apply_setting(63, -32768, 32767);
          load_table(n, -400, 0);
        end
        3: begin
          n = 3;
          apply_setting(3, 32767, -32768);
          load_table(n, 0, -400);
        end
        4: begin
          n = 1;
          apply_setting(1, $urandom_range(0, 200) - 100, $urandom_range(0, 200) - 100);
          load_table(n, 10, 10);
        end
        5: begin
          apply_setting(0, 0, 0);
          lay_n = 0;
        end
        default: begin
          n = 20;
          gaps_on = 1'b0;
          apply_setting(20, $urandom_range(0, 40) - 20, $urandom_range(0, 40) - 20);
          load_table(n, -20, -30);
        end
      endcase
      for (k = 0; k < 13; k++) begin
        if (ph == 1 && k == 6) wait_drained();
        if ($urandom_range(0, 14) == 0) begin
          send_entry($urandom_range(0, 31), $urandom_range(0, 65535) - 32768,
                     $urandom_range(0, 65535) - 32768, $urandom_range(0, 65535) - 32768,
                     $urandom_range(0, 65535) - 32768);
        end
        send_word(make_clip());
      end
    end

    start = 1'b0;
    for (k = 0; k < 20000 && pending != 0; k++) @(negedge clk);
    repeat (150) @(negedge clk);
    drain_done = 1'b1;
    repeat (2) @(negedge clk);
    $display("Run covered %0d clip requests, %0d table writes and %0d register writes.",
             clip_count, write_count, cfg_count);
    $display("%0d pieces were compared with the predicted clip list.", piece_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
